// ===== rtl/swt_pkg.sv =====
// shared types and constants for the shell line word tokenizer
package swt_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_WORD_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END = 2'd2;

  // line status codes
  localparam logic [2:0] STAT_OK     = 3'd0;
  localparam logic [2:0] STAT_LONG   = 3'd1;
  localparam logic [2:0] STAT_NUL    = 3'd2;
  localparam logic [2:0] STAT_EXTRA  = 3'd3;
  localparam logic [2:0] STAT_WORDS  = 3'd4;
  localparam logic [2:0] STAT_WLONG  = 3'd5;
  localparam logic [2:0] STAT_ESC    = 3'd6;
  localparam logic [2:0] STAT_QUOTE  = 3'd7;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  // result queue
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = 3;
  localparam int Q_CW    = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] word_number;
    logic [7:0] data_byte;
    logic [7:0] word_length;
    logic [5:0] word_total;
    logic [2:0] status;
    logic       last;
  } result_t;

endpackage

// ===== rtl/shell_line_word_tokenizer.sv =====
// shell line word tokenizer: byte stream in, word bytes / word ends / line ends out
//
//  channel  dir  payload                                              handshake
//  s_*      in   tdata[7:0] byte_in, tlast line_end                   tvalid/tready
//  m_*      out  tdata word_number,data_byte,word_length,             tvalid/tready
//                word_total,status; tuser kind; tlast last
//
// one byte per cycle: a byte is taken into an input register and decoded from there,
// once the queue has room, into zero to three words that go into an eight-entry result
// queue. one word leaves per cycle while m_tready is high, so bytes that make several
// words slow the input once the queue has fewer than three free entries. rst
// (synchronous) clears the scan state, the input register and the queue. a stalled
// output never blocks input while the queue has room.
module shell_line_word_tokenizer #(
  parameter int MAX_LINE_BYTES = 1024,
  parameter int MAX_WORD_BYTES = 256,
  parameter int MAX_WORDS      = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [4:0] word_number, [12:5] data_byte,
                                 // [20:13] word_length, [26:21] word_total,
                                 // [29:27] status, [31:30] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);
  import swt_pkg::*;

  localparam int LBW = $clog2(MAX_LINE_BYTES + 2);
  localparam int CLW = (MAX_WORD_BYTES > 2) ? $clog2(MAX_WORD_BYTES) : 1;
  localparam int WCW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS + 1) : 1;

  typedef enum logic [2:0] {
    M_BETWEEN, M_BARE, M_SQUOTE, M_DQUOTE, M_DQESC, M_COMMENT, M_DONE
  } mode_t;

  function automatic result_t mk_res(logic [1:0] k, logic [4:0] wn, logic [7:0] d,
                                     logic [7:0] wl, logic [5:0] wt, logic [2:0] st,
                                     logic lst);
    result_t r;
    r.kind        = k;
    r.word_number = wn;
    r.data_byte   = d;
    r.word_length = wl;
    r.word_total  = wt;
    r.status      = st;
    r.last        = lst;
    return r;
  endfunction

  function automatic logic [2:0] keep_err(logic [2:0] err, logic [2:0] code);
    return (err == STAT_OK) ? code : err;
  endfunction

  // scan state
  mode_t            mode, mode_next;
  logic [WCW-1:0]   wc, wc_next;
  logic [CLW-1:0]   cwl, cwl_next;
  logic [LBW-1:0]   lbc, lbc_next;
  logic [2:0]       err, err_next;

  // input register
  logic             in_vld;
  logic [7:0]       in_byte;
  logic             in_end;

  // result queue
  result_t          q [Q_DEPTH];
  logic [Q_AW-1:0]  wptr, rptr;
  logic [Q_CW-1:0]  cnt;

  result_t          res_next [3];
  logic [1:0]       n_next;
  logic             room, proc, pop;
  logic [1:0]       npush;

  assign room     = cnt <= Q_CW'(Q_DEPTH - 3);
  assign proc     = in_vld && room;
  assign s_tready = !in_vld || room;
  assign m_tvalid = cnt != '0;
  assign pop      = m_tvalid && m_tready;
  assign npush    = proc ? n_next : 2'd0;

  assign m_tdata  = {2'b00, q[rptr].status, q[rptr].word_total, q[rptr].word_length,
                     q[rptr].data_byte, q[rptr].word_number};
  assign m_tuser  = q[rptr].kind;
  assign m_tlast  = q[rptr].last;

  always_comb begin
    logic       do_push;
    logic       do_fin;
    logic [7:0] push_d;
    logic       blank;
    mode_next = mode;
    wc_next   = wc;
    cwl_next  = cwl;
    lbc_next  = lbc;
    err_next  = err;
    n_next    = 2'd0;
    do_push   = 1'b0;
    do_fin    = 1'b0;
    push_d    = in_byte;
    blank     = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_CR);
    for (int i = 0; i < 3; i++) begin
      res_next[i] = '0;
    end

    if (lbc <= LBW'(MAX_LINE_BYTES)) begin
      lbc_next = lbc + 1'b1;
    end
    if (lbc_next > LBW'(MAX_LINE_BYTES)) begin
      err_next  = STAT_LONG;
      mode_next = M_DONE;
    end

    // a word start from between words falls into the bare-word decode
    if (mode_next == M_BETWEEN) begin
      priority if (blank) begin
      end else if (in_byte == CH_LF) begin
        if (in_end) begin
          mode_next = M_COMMENT;
        end else begin
          err_next  = keep_err(err_next, STAT_EXTRA);
          mode_next = M_DONE;
        end
      end else if (in_byte == CH_HASH) begin
        mode_next = M_COMMENT;
      end else if (wc >= WCW'(MAX_WORDS)) begin
        err_next  = keep_err(err_next, STAT_WORDS);
        mode_next = M_DONE;
      end else begin
        cwl_next  = '0;
        mode_next = M_BARE;
      end
    end

    unique case (mode_next)
      M_BARE: begin
        priority if (in_byte == CH_NUL) begin
          err_next  = keep_err(err_next, STAT_NUL);
          mode_next = M_DONE;
        end else if (blank) begin
          do_fin    = 1'b1;
          mode_next = M_BETWEEN;
        end else if (in_byte == CH_LF) begin
          do_fin = 1'b1;
          if (in_end) begin
            mode_next = M_COMMENT;
          end else begin
            err_next  = keep_err(err_next, STAT_EXTRA);
            mode_next = M_DONE;
          end
        end else if (in_byte == CH_HASH) begin
          do_fin    = 1'b1;
          mode_next = M_COMMENT;
        end else if (in_byte == CH_DQUOTE) begin
          mode_next = M_DQUOTE;
        end else if (in_byte == CH_SQUOTE) begin
          mode_next = M_SQUOTE;
        end else begin
          do_push = 1'b1;
        end
      end
      M_SQUOTE: begin
        priority if (in_byte == CH_NUL) begin
          err_next  = keep_err(err_next, STAT_NUL);
          mode_next = M_DONE;
        end else if (in_byte == CH_SQUOTE) begin
          mode_next = M_BARE;
        end else begin
          do_push = 1'b1;
        end
      end
      M_DQUOTE: begin
        priority if (in_byte == CH_NUL) begin
          err_next  = keep_err(err_next, STAT_NUL);
          mode_next = M_DONE;
        end else if (in_byte == CH_DQUOTE) begin
          mode_next = M_BARE;
        end else if (in_byte == CH_BSLASH) begin
          if (in_end) begin
            err_next  = keep_err(err_next, STAT_ESC);
            mode_next = M_DONE;
          end else begin
            mode_next = M_DQESC;
          end
        end else begin
          do_push = 1'b1;
        end
      end
      M_DQESC: begin
        mode_next = M_DQUOTE;
        do_push   = 1'b1;
        priority if (in_byte == CH_N) begin
          push_d = CH_LF;
        end else if (in_byte == CH_T) begin
          push_d = CH_TAB;
        end else if (in_byte == CH_R) begin
          push_d = CH_CR;
        end else if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE
                     || in_byte == CH_BSLASH) begin
          push_d = in_byte;
        end else begin
          do_push   = 1'b0;
          err_next  = keep_err(err_next, STAT_ESC);
          mode_next = M_DONE;
        end
      end
      default: begin
      end
    endcase

    if (do_fin) begin
      res_next[n_next] = mk_res(KIND_WORD_END, 5'(wc_next), 8'd0, 8'(cwl_next), 6'd0,
                                STAT_OK, 1'b0);
      n_next   = n_next + 1'b1;
      wc_next  = wc_next + 1'b1;
      cwl_next = '0;
    end
    if (do_push) begin
      // the word keeps room for a terminator
      if (cwl_next >= CLW'(MAX_WORD_BYTES - 1)) begin
        err_next  = keep_err(err_next, STAT_WLONG);
        mode_next = M_DONE;
      end else begin
        res_next[n_next] = mk_res(KIND_BYTE, 5'(wc_next), push_d, 8'd0, 6'd0,
                                  STAT_OK, 1'b0);
        n_next   = n_next + 1'b1;
        cwl_next = cwl_next + 1'b1;
      end
    end

    if (in_end) begin
      if (mode_next == M_BARE) begin
        res_next[n_next] = mk_res(KIND_WORD_END, 5'(wc_next), 8'd0, 8'(cwl_next), 6'd0,
                                  STAT_OK, 1'b0);
        n_next  = n_next + 1'b1;
        wc_next = wc_next + 1'b1;
      end else if (mode_next == M_SQUOTE || mode_next == M_DQUOTE
                   || mode_next == M_DQESC) begin
        err_next = keep_err(err_next, STAT_QUOTE);
      end
      res_next[n_next] = mk_res(KIND_LINE_END, 5'd0, 8'd0, 8'd0, 6'(wc_next), err_next,
                                1'b1);
      n_next    = n_next + 1'b1;
      mode_next = M_BETWEEN;
      wc_next   = '0;
      cwl_next  = '0;
      lbc_next  = '0;
      err_next  = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_BETWEEN;
      wc     <= '0;
      cwl    <= '0;
      lbc    <= '0;
      err    <= STAT_OK;
      in_vld <= 1'b0;
      wptr   <= '0;
      rptr   <= '0;
      cnt    <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_vld  <= 1'b1;
        in_byte <= s_tdata;
        in_end  <= s_tlast;
      end else if (proc) begin
        in_vld <= 1'b0;
      end
      if (proc) begin
        mode <= mode_next;
        wc   <= wc_next;
        cwl  <= cwl_next;
        lbc  <= lbc_next;
        err  <= err_next;
      end
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < npush) begin
          q[wptr + Q_AW'(i)] <= res_next[i];
        end
      end
      wptr <= wptr + Q_AW'(npush);
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      cnt <= cnt + Q_CW'(npush) - Q_CW'(pop);
    end
  end

endmodule
